// ===== src/grid_footprint_outline_macros.svh =====
// assertion macros for the grid footprint outline checker
`ifndef GRID_FOOTPRINT_OUTLINE_MACROS_SVH
`define GRID_FOOTPRINT_OUTLINE_MACROS_SVH

// property checked on every clock, off while in reset
`define GFO_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// consequent checked on the clock after the antecedent
`define GFO_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) ante |=> cons) else $error(msg);

`endif

// ===== src/gfo_pkg.sv =====
// shared codes, widths and types of the grid footprint outline block
`default_nettype none

package gfo_pkg;

  localparam int CMD_W      = 2;
  localparam int CELL_W     = 3;
  localparam int LINE_W     = 4;
  localparam int PX_X_W     = 9;
  localparam int PX_Y_W     = 8;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;

  localparam int PIX_X_STEP = 30;
  localparam int PIX_Y_STEP = 15;

  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ADD    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SCAN_H = 2'd2;
  localparam logic [CMD_W-1:0] CMD_SCAN_V = 2'd3;

  localparam logic [STATUS_W-1:0] STATUS_SEG    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_REJECT = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'd1;

  localparam logic [CFG_DATA_W-1:0] SIDE_RESET = 4'd1;

  typedef struct packed {
    logic              clear;
    logic              toggle;
    logic [CELL_W-1:0] cx;
    logic [CELL_W-1:0] cy;
  } edge_cmd_t;

endpackage

`default_nettype wire

// ===== src/gfo_iso.sv =====
// grid corner to isometric pixel conversion unit
`default_nettype none

module gfo_iso #(
  parameter int MAX_SIDE = 8,
  localparam int SIDE_W = $clog2(MAX_SIDE + 1)
) (
  input  logic [SIDE_W-1:0]                gx,
  input  logic [SIDE_W-1:0]                gy,
  output logic signed [gfo_pkg::PX_X_W-1:0] px_x,
  output logic [gfo_pkg::PX_Y_W-1:0]        px_y
);

  logic signed [SIDE_W+1:0] diff;
  logic [SIDE_W:0]          sum;
  int                       prod_x;
  int                       prod_y;

  always_comb begin
    diff   = $signed({2'b00, gx}) - $signed({2'b00, gy});
    sum    = {1'b0, gx} + {1'b0, gy};
    prod_x = int'(diff) * gfo_pkg::PIX_X_STEP;
    prod_y = int'(sum) * gfo_pkg::PIX_Y_STEP;
    px_x   = prod_x[gfo_pkg::PX_X_W-1:0];
    px_y   = prod_y[gfo_pkg::PX_Y_W-1:0];
  end

endmodule

`default_nettype wire

// ===== src/gfo_edges.sv =====
// row and column edge bitmaps with cell toggle and line read
`default_nettype none

module gfo_edges #(
  parameter int MAX_SIDE = 8,
  localparam int SIDE_W = $clog2(MAX_SIDE + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  gfo_pkg::edge_cmd_t edge_cmd,
  input  logic               rd_vert,
  input  logic [SIDE_W-1:0]  rd_line,
  output logic [MAX_SIDE-1:0] rd_bits
);

  logic [MAX_SIDE-1:0] row_edges [MAX_SIDE+1];
  logic [MAX_SIDE-1:0] column_edges [MAX_SIDE+1];
  logic [MAX_SIDE-1:0] x_bit;
  logic [MAX_SIDE-1:0] y_bit;

  always_comb begin
    for (int b = 0; b < MAX_SIDE; b++) begin
      x_bit[b] = (int'(edge_cmd.cx) == b);
      y_bit[b] = (int'(edge_cmd.cy) == b);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || edge_cmd.clear) begin
      for (int r = 0; r <= MAX_SIDE; r++) begin
        row_edges[r]    <= '0;
        column_edges[r] <= '0;
      end
    end else if (edge_cmd.toggle) begin
      for (int r = 0; r <= MAX_SIDE; r++) begin
        if (int'(edge_cmd.cy) == r || int'(edge_cmd.cy) + 1 == r) begin
          row_edges[r] <= row_edges[r] ^ x_bit;
        end
        if (int'(edge_cmd.cx) == r || int'(edge_cmd.cx) + 1 == r) begin
          column_edges[r] <= column_edges[r] ^ y_bit;
        end
      end
    end
  end

  always_comb begin
    rd_bits = '0;
    if (int'(rd_line) <= MAX_SIDE) begin
      rd_bits = rd_vert ? column_edges[rd_line] : row_edges[rd_line];
    end
  end

endmodule

`default_nettype wire

// ===== src/grid_footprint_outline.sv =====
// top level: command sequencer, line scan and result register
// add and clear take effect on the accepting edge; cmd_stall is low in idle
// a rejected add or an empty line passes through ST_STATUS to its status result
// a scan walks one edge bit per cycle, unless res_stall holds it, through the
// shared pixel unit; the next command is taken after its last segment
// rst clears both edge bitmaps at once and sets width and height to one
`default_nettype none

module grid_footprint_outline #(
  parameter int MAX_SIDE = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [gfo_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [gfo_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               cmd_valid,
  output logic                               cmd_stall,
  input  logic [gfo_pkg::CMD_W-1:0]          command,
  input  logic [gfo_pkg::CELL_W-1:0]         cell_x,
  input  logic [gfo_pkg::CELL_W-1:0]         cell_y,
  input  logic [gfo_pkg::LINE_W-1:0]         line_index,
  output logic                               res_valid,
  input  logic                               res_stall,
  output logic signed [gfo_pkg::PX_X_W-1:0]  start_px_x,
  output logic [gfo_pkg::PX_Y_W-1:0]         start_px_y,
  output logic signed [gfo_pkg::PX_X_W-1:0]  end_px_x,
  output logic [gfo_pkg::PX_Y_W-1:0]         end_px_y,
  output logic [gfo_pkg::STATUS_W-1:0]       status,
  output logic                               last
);

  localparam int SIDE_W = $clog2(MAX_SIDE + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_STATUS, ST_SCAN} state_t;

  state_t                             state;
  logic [gfo_pkg::CFG_DATA_W-1:0]     foot_width;
  logic [gfo_pkg::CFG_DATA_W-1:0]     foot_height;
  logic [gfo_pkg::STATUS_W-1:0]       pend_status;
  logic [MAX_SIDE-1:0]                scan_bits;
  logic [SIDE_W-1:0]                  scan_len;
  logic [SIDE_W-1:0]                  scan_pos;
  logic [SIDE_W-1:0]                  scan_line;
  logic                               scan_vert;
  logic                               run_on;
  logic signed [gfo_pkg::PX_X_W-1:0]  run_px_x;
  logic [gfo_pkg::PX_Y_W-1:0]         run_px_y;

  logic [SIDE_W-1:0]                  w_side;
  logic [SIDE_W-1:0]                  h_side;
  logic [SIDE_W-1:0]                  line_limit;
  logic [SIDE_W-1:0]                  sel_len;
  logic [MAX_SIDE-1:0]                len_mask;
  logic [MAX_SIDE-1:0]                rd_bits;
  logic [MAX_SIDE-1:0]                load_bits;
  logic                               is_vert_cmd;
  logic                               line_bad;
  logic                               add_ok;
  logic                               accept;
  logic                               slot_free;
  logic                               set_now;
  logic                               need_emit;
  logic                               rest_empty;
  logic                               scan_go;
  logic                               res_load;
  logic [SIDE_W-1:0]                  iso_gx;
  logic [SIDE_W-1:0]                  iso_gy;
  logic signed [gfo_pkg::PX_X_W-1:0]  iso_px_x;
  logic [gfo_pkg::PX_Y_W-1:0]         iso_px_y;
  gfo_pkg::edge_cmd_t                 edge_cmd;

  always_comb begin
    w_side = (int'(foot_width) > MAX_SIDE) ? SIDE_W'(MAX_SIDE) : SIDE_W'(foot_width);
    h_side = (int'(foot_height) > MAX_SIDE) ? SIDE_W'(MAX_SIDE) : SIDE_W'(foot_height);
    is_vert_cmd = (command == gfo_pkg::CMD_SCAN_V);
    line_limit  = is_vert_cmd ? w_side : h_side;
    sel_len     = is_vert_cmd ? h_side : w_side;
    line_bad    = int'(line_index) > int'(line_limit);
    for (int b = 0; b < MAX_SIDE; b++) begin
      len_mask[b] = (b < int'(sel_len));
    end
    load_bits = rd_bits & len_mask;
    add_ok    = (int'(cell_x) < int'(w_side)) && (int'(cell_y) < int'(h_side));
    accept    = cmd_valid && (state == ST_IDLE);

    edge_cmd.clear  = accept && (command == gfo_pkg::CMD_CLEAR);
    edge_cmd.toggle = accept && (command == gfo_pkg::CMD_ADD) && add_ok;
    edge_cmd.cx     = cell_x;
    edge_cmd.cy     = cell_y;

    slot_free  = !res_valid || !res_stall;
    set_now    = scan_bits[0] && (scan_pos != scan_len);
    need_emit  = run_on && !set_now;
    rest_empty = ((scan_bits >> 1) == '0);
    scan_go    = !need_emit || slot_free;
    res_load   = ((state == ST_STATUS) && slot_free) ||
                 ((state == ST_SCAN) && scan_go && need_emit);
    iso_gx     = scan_vert ? scan_line : scan_pos;
    iso_gy     = scan_vert ? scan_pos : scan_line;
  end

  assign cmd_stall = (state != ST_IDLE);
  assign cfg_ready = 1'b1;

  gfo_edges #(.MAX_SIDE(MAX_SIDE)) u_edges (
    .clk      (clk),
    .rst      (rst),
    .edge_cmd (edge_cmd),
    .rd_vert  (is_vert_cmd),
    .rd_line  (SIDE_W'(line_index)),
    .rd_bits  (rd_bits)
  );

  gfo_iso #(.MAX_SIDE(MAX_SIDE)) u_iso (
    .gx   (iso_gx),
    .gy   (iso_gy),
    .px_x (iso_px_x),
    .px_y (iso_px_y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      foot_width  <= gfo_pkg::SIDE_RESET;
      foot_height <= gfo_pkg::SIDE_RESET;
      res_valid   <= 1'b0;
      run_on      <= 1'b0;
    end else begin
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
      if (cfg_valid) begin
        case (cfg_index)
          gfo_pkg::CFG_WIDTH:  foot_width  <= cfg_data;
          gfo_pkg::CFG_HEIGHT: foot_height <= cfg_data;
          default: ;
        endcase
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            case (command)
              gfo_pkg::CMD_ADD: begin
                if (!add_ok) begin
                  pend_status <= gfo_pkg::STATUS_REJECT;
                  state       <= ST_STATUS;
                end
              end
              gfo_pkg::CMD_SCAN_H, gfo_pkg::CMD_SCAN_V: begin
                if (line_bad || load_bits == '0) begin
                  pend_status <= gfo_pkg::STATUS_EMPTY;
                  state       <= ST_STATUS;
                end else begin
                  scan_bits <= load_bits;
                  scan_len  <= sel_len;
                  scan_pos  <= '0;
                  scan_line <= SIDE_W'(line_index);
                  scan_vert <= is_vert_cmd;
                  run_on    <= 1'b0;
                  state     <= ST_SCAN;
                end
              end
              default: ;
            endcase
          end
        end
        ST_STATUS: begin
          if (slot_free) begin
            start_px_x <= '0;
            start_px_y <= '0;
            end_px_x   <= '0;
            end_px_y   <= '0;
            status     <= pend_status;
            last       <= 1'b1;
            state      <= ST_IDLE;
          end
        end
        ST_SCAN: begin
          if (scan_go) begin
            if (set_now && !run_on) begin
              run_px_x <= iso_px_x;
              run_px_y <= iso_px_y;
              run_on   <= 1'b1;
            end
            if (need_emit) begin
              start_px_x <= run_px_x;
              start_px_y <= run_px_y;
              end_px_x   <= iso_px_x;
              end_px_y   <= iso_px_y;
              status     <= gfo_pkg::STATUS_SEG;
              last       <= rest_empty;
              run_on     <= 1'b0;
              if (rest_empty) begin
                state <= ST_IDLE;
              end
            end
            scan_pos  <= scan_pos + 1'b1;
            scan_bits <= scan_bits >> 1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== src/gfo_checker.sv =====
// port level assertions for the grid footprint outline block and their bind
`default_nettype none
`include "grid_footprint_outline_macros.svh"

module gfo_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               cmd_valid,
  input logic                               cmd_stall,
  input logic [gfo_pkg::CMD_W-1:0]          command,
  input logic                               res_valid,
  input logic                               res_stall,
  input logic signed [gfo_pkg::PX_X_W-1:0]  start_px_x,
  input logic [gfo_pkg::PX_Y_W-1:0]         start_px_y,
  input logic signed [gfo_pkg::PX_X_W-1:0]  end_px_x,
  input logic [gfo_pkg::PX_Y_W-1:0]         end_px_y,
  input logic [gfo_pkg::STATUS_W-1:0]       status,
  input logic                               last
);

  // held result transaction keeps its payload
  `GFO_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(status) && $stable(last) && $stable(start_px_x) && $stable(start_px_y) && $stable(end_px_x) && $stable(end_px_y), "stalled result changed")

  // status results carry zero coordinates and close the command
  `GFO_ASSERT(a_status_form, res_valid && status != gfo_pkg::STATUS_SEG |-> last && start_px_x == 0 && start_px_y == 0 && end_px_x == 0 && end_px_y == 0, "malformed status result")

  // a clear never blocks the next command
  `GFO_ASSERT_NEXT(a_clear_free, cmd_valid && !cmd_stall && command == gfo_pkg::CMD_CLEAR, !cmd_stall, "busy after clear")

endmodule

bind grid_footprint_outline gfo_checker u_gfo_checker (.*);

`default_nettype wire
